// ===== src/ksit_pkg.sv =====
// Shared types and constants of the keyed sequential item table.
// Holds the entry, item and result records plus the controller/datapath link.
// No dependencies.
package ksit_pkg;

  localparam int unsigned NameWords  = 4;
  localparam int unsigned KindWords  = 3;
  localparam int unsigned WordW      = 64;
  localparam int unsigned AmountW    = 32;
  localparam int unsigned SlotW      = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_LIST   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Where the reported entry of a result comes from.
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_ITEM = 2'd1,
    SRC_RAM  = 2'd2
  } out_src_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INSERT,
    S_FIND_RD,
    S_FIND_CMP,
    S_FOUND,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LIST_RD,
    S_LIST_EMIT
  } state_e;

  typedef struct packed {
    logic [NameWords-1:0][WordW-1:0] key;
    logic [KindWords-1:0][WordW-1:0] kind;
    logic signed [AmountW-1:0]       amount;
  } entry_t;

  typedef struct packed {
    opcode_e opcode;
    entry_t  entry;
  } item_t;

  typedef struct packed {
    status_e          status;
    entry_t           entry;
    logic [SlotW-1:0] slot;
    logic             last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_item;
    logic     idx_clr;
    logic     idx_inc;
    logic     ram_re;
    logic     rd_next;
    logic     ram_we;
    logic     wr_shift;
    logic     count_inc;
    logic     count_dec;
    logic     out_load;
    out_src_e out_src;
    status_e  out_status;
    logic     out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    opcode_e in_op;
    opcode_e op;
    logic    full;
    logic    empty;
    logic    idx_end;
    logic    idx_last;
    logic    match;
    logic    out_free;
  } stat_t;

endpackage

// ===== src/ksit_in_if.sv =====
// Command channel of the keyed sequential item table: valid, ready and one command beat.
// Depends on nothing.
interface ksit_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [63:0]        key_word0;
  logic [63:0]        key_word1;
  logic [63:0]        key_word2;
  logic [63:0]        key_word3;
  logic [63:0]        kind_word0;
  logic [63:0]        kind_word1;
  logic [63:0]        kind_word2;
  logic signed [31:0] amount;

  modport source (
    output valid, opcode, key_word0, key_word1, key_word2, key_word3,
           kind_word0, kind_word1, kind_word2, amount,
    input  ready
  );

  modport sink (
    input  valid, opcode, key_word0, key_word1, key_word2, key_word3,
           kind_word0, kind_word1, kind_word2, amount,
    output ready
  );
endinterface

// ===== src/ksit_out_if.sv =====
// Result channel of the keyed sequential item table: valid, ready and one result beat.
// Depends on nothing.
interface ksit_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [63:0]        out_key_word0;
  logic [63:0]        out_key_word1;
  logic [63:0]        out_key_word2;
  logic [63:0]        out_key_word3;
  logic [63:0]        out_kind_word0;
  logic [63:0]        out_kind_word1;
  logic [63:0]        out_kind_word2;
  logic signed [31:0] out_amount;
  logic [3:0]         slot;
  logic               last;

  modport source (
    output valid, status, out_key_word0, out_key_word1, out_key_word2, out_key_word3,
           out_kind_word0, out_kind_word1, out_kind_word2, out_amount, slot, last,
    input  ready
  );

  modport sink (
    input  valid, status, out_key_word0, out_key_word1, out_key_word2, out_key_word3,
           out_kind_word0, out_kind_word1, out_kind_word2, out_amount, slot, last,
    output ready
  );
endinterface

// ===== src/ksit_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module ksit_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/ksit_datapath.sv =====
// Datapath of the keyed sequential item table: command register, entry RAM,
// slot index, entry count and the result register. Uses ksit_pkg and ksit_ram.
module ksit_datapath #(
  parameter int unsigned CAPACITY = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ksit_pkg::item_t  item_i,
  input  ksit_pkg::cmd_t   cmd_i,
  output ksit_pkg::stat_t  stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ksit_pkg::result_t out_result_o
);

  localparam int unsigned IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned SlotW = ksit_pkg::SlotW;

  ksit_pkg::item_t   item_q;
  ksit_pkg::entry_t  rdata;
  ksit_pkg::entry_t  wdata;
  ksit_pkg::result_t out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW:0]     idx_plus;
  logic [IdxW-1:0]   raddr, waddr;
  logic [CntW-1:0]   slot_pos;
  logic [CntW+SlotW-1:0] slot_wide;

  assign idx_plus = {1'b0, idx_q} + (CntW + 1)'(1);

  // Captured command beat: opcode and entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
  end

  // Slot index and entry count.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_plus[CntW-1:0];
    end
    count_d = count_q;
    if (cmd_i.count_inc) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.count_dec) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      idx_q   <= idx_d;
      count_q <= count_d;
    end
  end

  // Entry RAM: appends at the count, shifts down at the index.
  assign raddr = cmd_i.rd_next ? idx_plus[IdxW-1:0] : idx_q[IdxW-1:0];
  assign waddr = cmd_i.wr_shift ? idx_q[IdxW-1:0] : count_q[IdxW-1:0];
  assign wdata = cmd_i.wr_shift ? rdata : item_q.entry;

  ksit_ram #(
    .WIDTH ($bits(ksit_pkg::entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Status toward the controller.
  always_comb begin
    stat_o.in_op    = item_i.opcode;
    stat_o.op       = item_q.opcode;
    stat_o.full     = (count_q == CntW'(CAPACITY));
    stat_o.empty    = (count_q == '0);
    stat_o.idx_end  = (idx_q == count_q);
    stat_o.idx_last = (idx_plus >= {1'b0, count_q});
    stat_o.match    = (rdata.key == item_q.entry.key);
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  // Result register; the slot keeps the low bits of the position.
  assign slot_pos  = (cmd_i.out_src == ksit_pkg::SRC_ITEM) ? count_q : idx_q;
  assign slot_wide = {SlotW'(0), slot_pos};

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d      = 1'b1;
      out_d.status     = cmd_i.out_status;
      out_d.last       = cmd_i.out_last;
      out_d.slot       = slot_wide[SlotW-1:0];
      unique case (cmd_i.out_src)
        ksit_pkg::SRC_ITEM: out_d.entry = item_q.entry;
        ksit_pkg::SRC_RAM:  out_d.entry = rdata;
        default: begin
          out_d.entry = '0;
          out_d.slot  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

endmodule

// ===== src/ksit_ctrl.sv =====
// Controller of the keyed sequential item table: one state machine that sequences
// insert, search, remove with shift-down, and list. Uses ksit_pkg.
module ksit_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ksit_pkg::stat_t stat_i,
  output ksit_pkg::cmd_t  cmd_o
);

  ksit_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ksit_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ksit_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (stat_i.in_op)
            ksit_pkg::OP_INSERT: state_d = ksit_pkg::S_INSERT;
            ksit_pkg::OP_LIST:   state_d = ksit_pkg::S_LIST_RD;
            default:             state_d = ksit_pkg::S_FIND_RD;
          endcase
        end
      end
      ksit_pkg::S_INSERT: begin
        if (stat_i.out_free) state_d = ksit_pkg::S_IDLE;
      end
      ksit_pkg::S_FIND_RD: begin
        if (!stat_i.idx_end) begin
          state_d = ksit_pkg::S_FIND_CMP;
        end else if (stat_i.out_free) begin
          state_d = ksit_pkg::S_IDLE;
        end
      end
      ksit_pkg::S_FIND_CMP: begin
        state_d = stat_i.match ? ksit_pkg::S_FOUND : ksit_pkg::S_FIND_RD;
      end
      ksit_pkg::S_FOUND: begin
        if (stat_i.out_free) begin
          state_d = (stat_i.op == ksit_pkg::OP_REMOVE) ? ksit_pkg::S_SHIFT_RD
                                                      : ksit_pkg::S_IDLE;
        end
      end
      ksit_pkg::S_SHIFT_RD: begin
        state_d = stat_i.idx_last ? ksit_pkg::S_IDLE : ksit_pkg::S_SHIFT_WR;
      end
      ksit_pkg::S_SHIFT_WR: begin
        state_d = ksit_pkg::S_SHIFT_RD;
      end
      ksit_pkg::S_LIST_RD: begin
        if (!stat_i.empty) begin
          state_d = ksit_pkg::S_LIST_EMIT;
        end else if (stat_i.out_free) begin
          state_d = ksit_pkg::S_IDLE;
        end
      end
      ksit_pkg::S_LIST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = stat_i.idx_last ? ksit_pkg::S_IDLE : ksit_pkg::S_LIST_RD;
        end
      end
      default: state_d = ksit_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_src    = ksit_pkg::SRC_NONE;
    cmd_o.out_status = ksit_pkg::ST_OK;
    in_ready_o       = (state_q == ksit_pkg::S_IDLE);
    unique case (state_q)
      ksit_pkg::S_IDLE: begin
        cmd_o.load_item = in_valid_i;
        cmd_o.idx_clr   = in_valid_i;
      end
      ksit_pkg::S_INSERT: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_last = 1'b1;
        if (stat_i.full) begin
          cmd_o.out_status = ksit_pkg::ST_FULL;
        end else begin
          cmd_o.out_src   = ksit_pkg::SRC_ITEM;
          cmd_o.ram_we    = stat_i.out_free;
          cmd_o.count_inc = stat_i.out_free;
        end
      end
      ksit_pkg::S_FIND_RD: begin
        if (stat_i.idx_end) begin
          cmd_o.out_load   = stat_i.out_free;
          cmd_o.out_status = ksit_pkg::ST_NOT_FOUND;
          cmd_o.out_last   = 1'b1;
        end else begin
          cmd_o.ram_re = 1'b1;
        end
      end
      ksit_pkg::S_FIND_CMP: begin
        cmd_o.idx_inc = !stat_i.match;
      end
      ksit_pkg::S_FOUND: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_src  = ksit_pkg::SRC_RAM;
        cmd_o.out_last = 1'b1;
      end
      ksit_pkg::S_SHIFT_RD: begin
        if (stat_i.idx_last) begin
          cmd_o.count_dec = 1'b1;
        end else begin
          cmd_o.ram_re  = 1'b1;
          cmd_o.rd_next = 1'b1;
        end
      end
      ksit_pkg::S_SHIFT_WR: begin
        cmd_o.ram_we   = 1'b1;
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
      end
      ksit_pkg::S_LIST_RD: begin
        if (stat_i.empty) begin
          cmd_o.out_load   = stat_i.out_free;
          cmd_o.out_status = ksit_pkg::ST_EMPTY;
          cmd_o.out_last   = 1'b1;
        end else begin
          cmd_o.ram_re = 1'b1;
        end
      end
      ksit_pkg::S_LIST_EMIT: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_src  = ksit_pkg::SRC_RAM;
        cmd_o.out_last = stat_i.idx_last;
        cmd_o.idx_inc  = stat_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/keyed_sequential_item_table_unit.sv =====
// Keyed sequential item table: an ordered table of up to CAPACITY named entries.
// Commands arrive on req_i and results leave on rsp_o, both valid/ready channels;
// a beat moves at a rising edge with valid and ready high.
// One command is worked on at a time; req_i.ready is high only while idle.
// Entries sit in one RAM with a single read port and a registered read, so
// each entry visited takes a read state and then a state that uses the data.
//   insert: appends the entry at the count and loads its result, or reports full.
//   search: reads and compares entries in order until a key matches or none are left.
//   remove: as search, then each later entry moves down one slot and the count drops.
//   list:   reads each entry in turn and emits it as one result beat;
//           last marks the final beat, and an empty table gives one beat with
//           the empty status.
// Results go through one output register, so the table goes on with the shift
// after a remove while its result still waits; a stall on rsp_o holds the block
// only when the next result needs that register.
// Reset empties the table and drops any pending result; entry RAM contents
// are not cleared, and no entry beyond the count is ever read.
// Uses ksit_pkg, ksit_in_if, ksit_out_if, ksit_ctrl, ksit_datapath.
module keyed_sequential_item_table_unit #(
  parameter int unsigned CAPACITY = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ksit_in_if.sink           req_i,
  ksit_out_if.source        rsp_o
);

  ksit_pkg::item_t   item;
  ksit_pkg::cmd_t    cmd;
  ksit_pkg::stat_t   stat;
  ksit_pkg::result_t result;
  logic              in_ready;
  logic              out_valid;

  // Pack the command beat.
  always_comb begin
    item.opcode             = ksit_pkg::opcode_e'(req_i.opcode);
    item.entry.key[0]       = req_i.key_word0;
    item.entry.key[1]       = req_i.key_word1;
    item.entry.key[2]       = req_i.key_word2;
    item.entry.key[3]       = req_i.key_word3;
    item.entry.kind[0]      = req_i.kind_word0;
    item.entry.kind[1]      = req_i.kind_word1;
    item.entry.kind[2]      = req_i.kind_word2;
    item.entry.amount       = req_i.amount;
  end

  assign req_i.ready = in_ready;

  ksit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ksit_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid),
    .out_ready_i  (rsp_o.ready),
    .out_result_o (result)
  );

  // Unpack the result beat.
  assign rsp_o.valid          = out_valid;
  assign rsp_o.status         = result.status;
  assign rsp_o.out_key_word0  = result.entry.key[0];
  assign rsp_o.out_key_word1  = result.entry.key[1];
  assign rsp_o.out_key_word2  = result.entry.key[2];
  assign rsp_o.out_key_word3  = result.entry.key[3];
  assign rsp_o.out_kind_word0 = result.entry.kind[0];
  assign rsp_o.out_kind_word1 = result.entry.kind[1];
  assign rsp_o.out_kind_word2 = result.entry.kind[2];
  assign rsp_o.out_amount     = result.entry.amount;
  assign rsp_o.slot           = result.slot;
  assign rsp_o.last           = result.last;

  // A command beat is never followed by another in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("command accepted while the previous one is in progress");

  // The result register is only loaded when it is empty or being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten before its beat was taken");

  // Every error status ends the command's results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ksit_pkg::ST_OK)) |-> rsp_o.last)
    else $error("error result without last");

  // The table is never written and read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.ram_we && cmd.ram_re))
    else $error("entry RAM read and written together");

endmodule

// ===== test/keyed_sequential_item_table_unit_tb.sv =====
// Testbench for keyed_sequential_item_table_unit: a directed table of commands, then random ones.
// Every result beat is checked against a table predictor kept inside the bench.
// Depends on ksit_pkg, ksit_in_if, ksit_out_if and the table unit itself.
module keyed_sequential_item_table_unit_tb;

  localparam int unsigned Capacity    = 10;
  localparam int unsigned NumPlan     = 25;
  localparam int unsigned RandomItems = 255;
  localparam int unsigned PoolSize    = 8;
  localparam int unsigned IdlePct     = 38;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxPrints   = 40;

  // Directed names and types; byte 0 of a field sits in bits 7:0.
  localparam logic [255:0] K_ZERO  = '0;
  localparam logic [255:0] K_ONES  = '1;
  localparam logic [255:0] K_APPLE = 256'h65_6c_70_70_61;
  // Same visible name as K_APPLE, but a stray byte after the zero padding.
  localparam logic [255:0] K_TAIL  = K_APPLE | (256'h7e << 248);
  // One bit away from K_APPLE; never stored.
  localparam logic [255:0] K_MISS  = K_APPLE ^ 256'h100;
  localparam logic [255:0] K_LAST  = 256'h74_73_61_6c;
  localparam logic [191:0] T_ZERO  = '0;
  localparam logic [191:0] T_ONES  = '1;
  localparam logic [191:0] T_FOOD  = 192'h64_6f_6f_66;

  typedef struct packed {
    ksit_pkg::opcode_e op;
    logic [255:0]      key;
    logic [191:0]      kind;
    logic [31:0]       amount;
    logic              fixed;
    ksit_pkg::status_e st;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  ksit_in_if  req ();
  ksit_out_if rsp ();

  keyed_sequential_item_table_unit #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i,
    .rst_ni,
    .req_i(req),
    .rsp_o(rsp)
  );

  // Predicted table contents and the result beats still owed by the block.
  ksit_pkg::entry_t  tbl_entry [Capacity];
  int unsigned       tbl_count;
  ksit_pkg::result_t want_beats [$];
  plan_row_t         plan [NumPlan];

  int unsigned errors;
  int unsigned beats_seen;
  int unsigned full_hits;
  int unsigned miss_hits;
  int unsigned empty_hits;
  int unsigned op_seen [4];
  int unsigned cyc;
  logic        calm;
  logic        hold_req;
  logic        hold_done;

  // Clock: period 10.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CycleLimit) begin
      $display("Cycle limit hit with %0d result beats outstanding.", want_beats.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report(string what);
    errors++;
    if (errors <= MaxPrints) begin
      $display("[cycle %0d] mismatch: %s", cyc, what);
    end
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  function automatic int find_key(
      logic [ksit_pkg::NameWords-1:0][ksit_pkg::WordW-1:0] key);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_entry[i].key == key) return i;
    end
    return -1;
  endfunction

  // Updates the predicted table for one accepted command and, when asked,
  // queues the result beats that the command owes.
  function automatic void apply_command(ksit_pkg::item_t it, logic keep);
    ksit_pkg::result_t r;
    int                pos;
    op_seen[it.opcode]++;
    r      = '0;
    r.last = 1'b1;
    case (it.opcode)
      ksit_pkg::OP_INSERT: begin
        if (tbl_count >= Capacity) begin
          r.status = ksit_pkg::ST_FULL;
          full_hits++;
        end else begin
          tbl_entry[tbl_count] = it.entry;
          r.status = ksit_pkg::ST_OK;
          r.entry  = it.entry;
          r.slot   = tbl_count[ksit_pkg::SlotW-1:0];
          tbl_count++;
        end
        if (keep) want_beats.push_back(r);
      end
      ksit_pkg::OP_REMOVE, ksit_pkg::OP_SEARCH: begin
        pos = find_key(it.entry.key);
        if (pos < 0) begin
          r.status = ksit_pkg::ST_NOT_FOUND;
          miss_hits++;
        end else begin
          r.status = ksit_pkg::ST_OK;
          r.entry  = tbl_entry[pos];
          r.slot   = pos[ksit_pkg::SlotW-1:0];
          // Removal closes the gap by moving every later entry down one slot.
          if (it.opcode == ksit_pkg::OP_REMOVE) begin
            for (int i = pos; i + 1 < tbl_count; i++) tbl_entry[i] = tbl_entry[i + 1];
            tbl_count--;
          end
        end
        if (keep) want_beats.push_back(r);
      end
      default: begin
        if (tbl_count == 0) begin
          r.status = ksit_pkg::ST_EMPTY;
          empty_hits++;
          if (keep) want_beats.push_back(r);
        end else begin
          for (int i = 0; i < tbl_count; i++) begin
            r.status = ksit_pkg::ST_OK;
            r.entry  = tbl_entry[i];
            r.slot   = i[ksit_pkg::SlotW-1:0];
            r.last   = (i + 1 == tbl_count);
            if (keep) want_beats.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // Compares one accepted result beat with the oldest expectation.
  task automatic check_beat();
    ksit_pkg::result_t want;
    beats_seen++;
    if (want_beats.size() == 0) begin
      report($sformatf("result beat (status %0d, slot %0d) with nothing expected",
                       rsp.status, rsp.slot));
      return;
    end
    want = want_beats.pop_front();
    check_field("status", 64'(rsp.status), 64'(want.status));
    check_field("key_word0", rsp.out_key_word0, want.entry.key[0]);
    check_field("key_word1", rsp.out_key_word1, want.entry.key[1]);
    check_field("key_word2", rsp.out_key_word2, want.entry.key[2]);
    check_field("key_word3", rsp.out_key_word3, want.entry.key[3]);
    check_field("kind_word0", rsp.out_kind_word0, want.entry.kind[0]);
    check_field("kind_word1", rsp.out_kind_word1, want.entry.kind[1]);
    check_field("kind_word2", rsp.out_kind_word2, want.entry.kind[2]);
    check_field("amount", 64'(rsp.out_amount), 64'(want.entry.amount));
    check_field("slot", 64'(rsp.slot), 64'(want.slot));
    check_field("last", 64'(rsp.last), 64'(want.last));
  endtask

  // Result monitor: values are sampled before this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid === 1'b1 && rsp.ready) check_beat();
  end

  // Result receiver: random stalls, a calm stretch, and one long hold-off.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        rsp.ready <= 1'b0;
        for (int c = 0; c < HoldCycles; c++) @(posedge clk_i);
        hold_done = 1'b1;
      end
      rsp.ready <= calm || ($urandom_range(99) >= IdlePct);
    end
  end

  // Text field with random content, zero padded after a random length.
  function automatic logic [255:0] rand_text(int unsigned nbytes);
    logic [255:0] t;
    int unsigned  len;
    t = '0;
    if ($urandom_range(3) == 0) len = nbytes;
    else len = $urandom_range(nbytes, 1);
    for (int b = 0; b < len; b++) t[b*8 +: 8] = 8'($urandom_range(255));
    return t;
  endfunction

  function automatic logic [31:0] rand_amount();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic ksit_pkg::item_t make_item(ksit_pkg::opcode_e op, logic [255:0] key,
                                                logic [191:0] kind, logic [31:0] amount);
    ksit_pkg::item_t it;
    it.opcode       = op;
    it.entry.key    = key;
    it.entry.kind   = kind;
    it.entry.amount = amount;
    return it;
  endfunction

  function automatic plan_row_t plan_row(ksit_pkg::opcode_e op, logic [255:0] key,
                                         logic [191:0] kind, logic [31:0] amount,
                                         logic fixed, ksit_pkg::status_e st);
    plan_row_t r;
    r.op     = op;
    r.key    = key;
    r.kind   = kind;
    r.amount = amount;
    r.fixed  = fixed;
    r.st     = st;
    return r;
  endfunction

  // Offers one command beat, with random idle cycles ahead of it, and returns
  // at the edge where the block takes it.
  task automatic offer(ksit_pkg::item_t it);
    while (!calm && $urandom_range(99) < IdlePct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.opcode     <= it.opcode;
    req.key_word0  <= it.entry.key[0];
    req.key_word1  <= it.entry.key[1];
    req.key_word2  <= it.entry.key[2];
    req.key_word3  <= it.entry.key[3];
    req.kind_word0 <= it.entry.kind[0];
    req.kind_word1 <= it.entry.kind[1];
    req.kind_word2 <= it.entry.kind[2];
    req.amount     <= it.entry.amount;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  initial begin
    ksit_pkg::item_t   it;
    ksit_pkg::result_t fixed_beat;
    logic [255:0]      name_pool [PoolSize];
    logic [255:0]      key;
    logic [255:0]      text;
    ksit_pkg::opcode_e op;
    int unsigned       pick;

    rst_ni         = 1'b0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    hold_done      = 1'b0;
    tbl_count      = 0;
    req.valid      = 1'b0;
    req.opcode     = ksit_pkg::OP_INSERT;
    req.key_word0  = '0;
    req.key_word1  = '0;
    req.key_word2  = '0;
    req.key_word3  = '0;
    req.kind_word0 = '0;
    req.kind_word1 = '0;
    req.kind_word2 = '0;
    req.amount     = '0;

    // Directed commands; fixed rows carry their error status, the rest use the predictor.
    plan[0]  = plan_row(ksit_pkg::OP_LIST, K_ZERO, T_ZERO, 32'h0, 1'b1, ksit_pkg::ST_EMPTY);
    plan[1]  = plan_row(ksit_pkg::OP_SEARCH, K_ZERO, T_ONES, 32'hffff_ffff, 1'b1,
                        ksit_pkg::ST_NOT_FOUND);
    plan[2]  = plan_row(ksit_pkg::OP_REMOVE, K_ONES, T_ZERO, 32'h0, 1'b1,
                        ksit_pkg::ST_NOT_FOUND);
    plan[3]  = plan_row(ksit_pkg::OP_INSERT, K_ZERO, T_ZERO, 32'h0, 1'b0, ksit_pkg::ST_OK);
    plan[4]  = plan_row(ksit_pkg::OP_INSERT, K_ONES, T_ONES, 32'h7fff_ffff, 1'b0,
                        ksit_pkg::ST_OK);
    plan[5]  = plan_row(ksit_pkg::OP_INSERT, K_APPLE, T_FOOD, 32'h8000_0000, 1'b0,
                        ksit_pkg::ST_OK);
    plan[6]  = plan_row(ksit_pkg::OP_INSERT, K_TAIL, T_FOOD, 32'hffff_ffff, 1'b0,
                        ksit_pkg::ST_OK);
    plan[7]  = plan_row(ksit_pkg::OP_INSERT, K_APPLE, T_ONES, 32'h1, 1'b0, ksit_pkg::ST_OK);
    plan[8]  = plan_row(ksit_pkg::OP_SEARCH, K_TAIL, T_ZERO, 32'h0, 1'b0, ksit_pkg::ST_OK);
    plan[9]  = plan_row(ksit_pkg::OP_SEARCH, K_APPLE, T_ZERO, 32'h0, 1'b0, ksit_pkg::ST_OK);
    plan[10] = plan_row(ksit_pkg::OP_INSERT, K_ONES, T_ZERO, 32'h2, 1'b0, ksit_pkg::ST_OK);
    plan[11] = plan_row(ksit_pkg::OP_INSERT, K_ONES, T_FOOD, 32'h3, 1'b0, ksit_pkg::ST_OK);
    plan[12] = plan_row(ksit_pkg::OP_INSERT, K_ONES, T_ONES, 32'h4, 1'b0, ksit_pkg::ST_OK);
    plan[13] = plan_row(ksit_pkg::OP_INSERT, K_ZERO, T_FOOD, 32'h5, 1'b0, ksit_pkg::ST_OK);
    plan[14] = plan_row(ksit_pkg::OP_INSERT, K_LAST, T_FOOD, 32'h6, 1'b0, ksit_pkg::ST_OK);
    plan[15] = plan_row(ksit_pkg::OP_INSERT, K_APPLE, T_ONES, 32'h7fff_ffff, 1'b1,
                        ksit_pkg::ST_FULL);
    plan[16] = plan_row(ksit_pkg::OP_LIST, K_ZERO, T_ZERO, 32'h0, 1'b0, ksit_pkg::ST_OK);
    plan[17] = plan_row(ksit_pkg::OP_SEARCH, K_MISS, T_ZERO, 32'h0, 1'b1,
                        ksit_pkg::ST_NOT_FOUND);
    plan[18] = plan_row(ksit_pkg::OP_REMOVE, K_APPLE, T_ZERO, 32'h0, 1'b0, ksit_pkg::ST_OK);
    plan[19] = plan_row(ksit_pkg::OP_REMOVE, K_ZERO, T_ZERO, 32'h0, 1'b0, ksit_pkg::ST_OK);
    plan[20] = plan_row(ksit_pkg::OP_SEARCH, K_APPLE, T_ZERO, 32'h0, 1'b0, ksit_pkg::ST_OK);
    plan[21] = plan_row(ksit_pkg::OP_REMOVE, K_LAST, T_ZERO, 32'h0, 1'b0, ksit_pkg::ST_OK);
    plan[22] = plan_row(ksit_pkg::OP_LIST, K_ONES, T_ONES, 32'hffff_ffff, 1'b0,
                        ksit_pkg::ST_OK);
    plan[23] = plan_row(ksit_pkg::OP_INSERT, K_LAST, T_ONES, 32'h8000_0000, 1'b0,
                        ksit_pkg::ST_OK);
    plan[24] = plan_row(ksit_pkg::OP_LIST, K_ZERO, T_ZERO, 32'h0, 1'b0, ksit_pkg::ST_OK);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumPlan; i++) begin
      it = make_item(plan[i].op, plan[i].key, plan[i].kind, plan[i].amount);
      offer(it);
      apply_command(it, !plan[i].fixed);
      if (plan[i].fixed) begin
        fixed_beat        = '0;
        fixed_beat.status = plan[i].st;
        fixed_beat.last   = 1'b1;
        want_beats.push_back(fixed_beat);
      end
    end

    // Random commands: alternating fill and drain phases walk the table
    // between empty and full; names mostly come from a small pool.
    for (int k = 0; k < PoolSize; k++) name_pool[k] = rand_text(32);
    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= 60 && n < 110);
      if (n == 150) hold_req = 1'b1;

      pick = $urandom_range(99);
      if ((n / 35) % 2 == 0) begin
        op = pick < 50 ? ksit_pkg::OP_INSERT :
             pick < 65 ? ksit_pkg::OP_REMOVE :
             pick < 82 ? ksit_pkg::OP_SEARCH : ksit_pkg::OP_LIST;
      end else begin
        op = pick < 15 ? ksit_pkg::OP_INSERT :
             pick < 60 ? ksit_pkg::OP_REMOVE :
             pick < 80 ? ksit_pkg::OP_SEARCH : ksit_pkg::OP_LIST;
      end

      pick = $urandom_range(99);
      if (op == ksit_pkg::OP_INSERT && pick < 20) begin
        name_pool[$urandom_range(PoolSize - 1)] = rand_text(32);
      end
      if (pick < 15) begin
        key = rand_text(32);
      end else if (pick < 27) begin
        // Near miss: a pool name with one bit flipped.
        key = name_pool[$urandom_range(PoolSize - 1)] ^ (256'b1 << $urandom_range(255));
      end else if (pick < 50 && tbl_count > 0) begin
        key = tbl_entry[$urandom_range(tbl_count - 1)].key;
      end else begin
        key = name_pool[$urandom_range(PoolSize - 1)];
      end

      text = rand_text(24);
      it   = make_item(op, key, text[191:0], rand_amount());
      offer(it);
      apply_command(it, 1'b1);
    end
    req.valid <= 1'b0;

    // Let the block finish any trailing shift after the last result.
    while (want_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d commands (%0d insert, %0d remove, %0d search, %0d list), %0d beats.",
             NumPlan + RandomItems, op_seen[ksit_pkg::OP_INSERT],
             op_seen[ksit_pkg::OP_REMOVE], op_seen[ksit_pkg::OP_SEARCH],
             op_seen[ksit_pkg::OP_LIST], beats_seen);
    $display("Table full %0d times, name misses %0d, empty lists %0d, mismatches %0d.",
             full_hits, miss_hits, empty_hits, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
